/* rtl/vmf_pkg.sv */
// Shared constants, types and helper functions of the 3D median filter.
package vmf_pkg;

    localparam int KERNEL_SIZE    = 3;
    localparam int MARGIN         = KERNEL_SIZE / 2;
    localparam int WIN            = 2 * MARGIN + 1;
    localparam int WIN_SQ         = WIN * WIN;
    localparam int WIN_CUBE       = WIN * WIN * WIN;
    localparam int MED_RANK       = WIN_CUBE / 2;
    localparam int SAMPLE_BITS    = 16;
    localparam int MAX_COLS       = 256;
    localparam int MAX_ROWS       = 256;
    localparam int MAX_SLICES     = 256;
    localparam int DIM_BITS       = 9;
    localparam int COORD_BITS     = 8;
    localparam int COL_BITS       = $clog2(MAX_COLS);
    localparam int BANK_ROWS      = (MAX_ROWS + WIN - 1) / WIN;
    localparam int BANK_ROW_BITS  = $clog2(BANK_ROWS);
    localparam int BANK_DEPTH     = BANK_ROWS * MAX_COLS;
    localparam int BANK_ADDR_BITS = BANK_ROW_BITS + COL_BITS;
    localparam int MOD_BITS       = $clog2(WIN);
    localparam int BANK_SEL_BITS  = $clog2(WIN_SQ);
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_BITS   = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DIM_COLS   = 2'd0,
        REG_DIM_ROWS   = 2'd1,
        REG_DIM_SLICES = 2'd2
    } cfg_reg_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t [WIN_SQ-1:0]          column_t;

    typedef struct packed {
        sample_t [WIN_CUBE-1:0] win;
        logic [COORD_BITS-1:0]  col;
        logic [COORD_BITS-1:0]  row;
        logic [COORD_BITS-1:0]  slice;
        logic                   last;
    } item_t;

    typedef struct packed {
        logic                 valid;
        logic [QCNT_BITS-1:0] level;
    } queue_status_t;

    // Largest position index for a dimension register: zero counts as one,
    // anything above the maximum counts as the maximum.
    function automatic logic [COORD_BITS-1:0] dim_limit(
        input logic [DIM_BITS-1:0] v,
        input logic [DIM_BITS:0]   maxv
    );
        logic [DIM_BITS:0] m;
        m = {1'b0, v};
        if (v == '0)
            return '0;
        else if (m > maxv)
            return COORD_BITS'(maxv - 1'b1);
        else
            return COORD_BITS'(m - 1'b1);
    endfunction

    // (x - d) mod WIN for x below WIN
    function automatic logic [MOD_BITS-1:0] mod_sub(
        input logic [MOD_BITS-1:0] x,
        input logic [MOD_BITS-1:0] d
    );
        if (x >= d)
            return MOD_BITS'(x - d);
        else
            return MOD_BITS'(x + MOD_BITS'(WIN) - d);
    endfunction

endpackage

/* rtl/vmf_if.sv */
// Channel interfaces: voxel input, median output and configuration write.
interface vmf_in_if;
    logic                        valid;
    logic                        ready;
    logic [vmf_pkg::SAMPLE_BITS-1:0] voxel_value;

    modport source (output valid, output voxel_value, input ready);
    modport sink   (input valid, input voxel_value, output ready);
endinterface

interface vmf_out_if;
    logic                            valid;
    logic                            ready;
    logic [vmf_pkg::SAMPLE_BITS-1:0] median_value;
    logic [vmf_pkg::COORD_BITS-1:0]  center_col;
    logic [vmf_pkg::COORD_BITS-1:0]  center_row;
    logic [vmf_pkg::COORD_BITS-1:0]  center_slice;
    logic                            last_interior;

    modport source (output valid, output median_value, output center_col,
                    output center_row, output center_slice, output last_interior,
                    input ready);
    modport sink   (input valid, input median_value, input center_col,
                    input center_row, input center_slice, input last_interior,
                    output ready);
endinterface

interface vmf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [vmf_pkg::CFG_IDX_BITS-1:0]  index;
    logic [vmf_pkg::DIM_BITS-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/vmf_front.sv */
// Front end: dimension registers, raster position, banked slice store, window columns.
module vmf_front (
    input  logic                   clk,
    input  logic                   rst_n,
    vmf_in_if.sink                 vox_in,
    vmf_cfg_if.sink                cfg,
    input  vmf_pkg::queue_status_t q_status,
    output logic                   push,
    output vmf_pkg::item_t         push_item
);

    logic [vmf_pkg::DIM_BITS-1:0]      dim_cols_reg, dim_rows_reg, dim_slices_reg;
    logic [vmf_pkg::COORD_BITS-1:0]    col_reg, row_reg, slice_reg;
    logic [vmf_pkg::COORD_BITS-1:0]    col_next, row_next, slice_next;
    logic [vmf_pkg::BANK_ROW_BITS-1:0] rdiv_reg, rdiv_next;
    logic [vmf_pkg::MOD_BITS-1:0]      rmod_reg, rmod_next, smod_reg, smod_next;
    logic [vmf_pkg::COORD_BITS-1:0]    lim_c, lim_r, lim_s;
    logic                              last_c, last_r, last_s;
    logic                              accept;
    logic [vmf_pkg::QCNT_BITS:0]       pending;

    logic                              v1_reg;
    logic                              emit1_reg;
    logic                              last1_reg;
    vmf_pkg::sample_t                  sample1_reg;
    logic [vmf_pkg::MOD_BITS-1:0]      smod1_reg, rmod1_reg;
    logic [vmf_pkg::COORD_BITS-1:0]    ccol1_reg, crow1_reg, cslice1_reg;

    vmf_pkg::sample_t                  bank_q [vmf_pkg::WIN_SQ];
    vmf_pkg::column_t                  new_col;
    vmf_pkg::column_t                  hist_reg [vmf_pkg::WIN-1];

    // Config writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_cols_reg   <= vmf_pkg::DIM_BITS'(vmf_pkg::MAX_COLS);
            dim_rows_reg   <= vmf_pkg::DIM_BITS'(vmf_pkg::MAX_ROWS);
            dim_slices_reg <= vmf_pkg::DIM_BITS'(vmf_pkg::MAX_SLICES);
        end
        else if (cfg.valid)
        begin
            unique case (vmf_pkg::cfg_reg_t'(cfg.index))
                vmf_pkg::REG_DIM_COLS:   dim_cols_reg   <= cfg.data;
                vmf_pkg::REG_DIM_ROWS:   dim_rows_reg   <= cfg.data;
                vmf_pkg::REG_DIM_SLICES: dim_slices_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Reserve a queue slot for every item that may still be in flight
    assign pending      = {1'b0, q_status.level} + (vmf_pkg::QCNT_BITS+1)'(v1_reg);
    assign vox_in.ready = pending < (vmf_pkg::QCNT_BITS+1)'(vmf_pkg::QUEUE_DEPTH);
    assign accept       = vox_in.valid && vox_in.ready;

    assign lim_c  = vmf_pkg::dim_limit(dim_cols_reg, (vmf_pkg::DIM_BITS+1)'(vmf_pkg::MAX_COLS));
    assign lim_r  = vmf_pkg::dim_limit(dim_rows_reg, (vmf_pkg::DIM_BITS+1)'(vmf_pkg::MAX_ROWS));
    assign lim_s  = vmf_pkg::dim_limit(dim_slices_reg,
                                       (vmf_pkg::DIM_BITS+1)'(vmf_pkg::MAX_SLICES));
    assign last_c = col_reg >= lim_c;
    assign last_r = row_reg >= lim_r;
    assign last_s = slice_reg >= lim_s;

    // Advance the raster position, tracking row and slice modulo the window
    always_comb
    begin
        col_next   = col_reg + 1'b1;
        row_next   = row_reg;
        slice_next = slice_reg;
        rdiv_next  = rdiv_reg;
        rmod_next  = rmod_reg;
        smod_next  = smod_reg;
        if (last_c)
        begin
            col_next = '0;
            if (!last_r)
            begin
                row_next = row_reg + 1'b1;
                if (rmod_reg == vmf_pkg::MOD_BITS'(vmf_pkg::WIN - 1))
                begin
                    rmod_next = '0;
                    rdiv_next = rdiv_reg + 1'b1;
                end
                else
                begin
                    rmod_next = rmod_reg + 1'b1;
                end
            end
            else
            begin
                row_next  = '0;
                rmod_next = '0;
                rdiv_next = '0;
                if (last_s)
                begin
                    slice_next = '0;
                    smod_next  = '0;
                end
                else
                begin
                    slice_next = slice_reg + 1'b1;
                    smod_next  = (smod_reg == vmf_pkg::MOD_BITS'(vmf_pkg::WIN - 1)) ?
                                 '0 : smod_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            slice_reg <= '0;
            rdiv_reg  <= '0;
            rmod_reg  <= '0;
            smod_reg  <= '0;
            v1_reg    <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            if (accept)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                slice_reg <= slice_next;
                rdiv_reg  <= rdiv_next;
                rmod_reg  <= rmod_next;
                smod_reg  <= smod_next;
            end
        end
    end

    // Hold the accepted voxel's details for the read-data cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample1_reg <= vox_in.voxel_value;
            smod1_reg   <= smod_reg;
            rmod1_reg   <= rmod_reg;
            emit1_reg   <= (col_reg >= vmf_pkg::COORD_BITS'(vmf_pkg::WIN - 1)) &&
                           (row_reg >= vmf_pkg::COORD_BITS'(vmf_pkg::WIN - 1)) &&
                           (slice_reg >= vmf_pkg::COORD_BITS'(vmf_pkg::WIN - 1));
            last1_reg   <= last_c && last_r && last_s;
            ccol1_reg   <= col_reg - vmf_pkg::COORD_BITS'(vmf_pkg::MARGIN);
            crow1_reg   <= row_reg - vmf_pkg::COORD_BITS'(vmf_pkg::MARGIN);
            cslice1_reg <= slice_reg - vmf_pkg::COORD_BITS'(vmf_pkg::MARGIN);
        end
    end

    // Slice store: one bank per (slice mod WIN, row mod WIN), each read once per voxel
    for (genvar k = 0; k < vmf_pkg::WIN_SQ; k++)
    begin : g_bank
        localparam int BA = k / vmf_pkg::WIN;
        localparam int BB = k % vmf_pkg::WIN;
        logic [vmf_pkg::SAMPLE_BITS-1:0]   mem [vmf_pkg::BANK_DEPTH];
        logic [vmf_pkg::BANK_ROW_BITS-1:0] rd_row;

        assign rd_row = (vmf_pkg::MOD_BITS'(BB) <= rmod_reg) ? rdiv_reg : rdiv_reg - 1'b1;

        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                if (smod_reg == vmf_pkg::MOD_BITS'(BA) && rmod_reg == vmf_pkg::MOD_BITS'(BB))
                    mem[{rdiv_reg, col_reg}] <= vox_in.voxel_value;
                bank_q[k] <= mem[{rd_row, col_reg}];
            end
        end
    end

    // Gather the column at the current position; the newest sample bypasses the store
    always_comb
    begin
        logic [vmf_pkg::MOD_BITS-1:0]      a;
        logic [vmf_pkg::MOD_BITS-1:0]      b;
        logic [vmf_pkg::BANK_SEL_BITS-1:0] sel;
        for (int ds = 0; ds < vmf_pkg::WIN; ds++)
        begin
            for (int dr = 0; dr < vmf_pkg::WIN; dr++)
            begin
                a   = vmf_pkg::mod_sub(smod1_reg, vmf_pkg::MOD_BITS'(ds));
                b   = vmf_pkg::mod_sub(rmod1_reg, vmf_pkg::MOD_BITS'(dr));
                sel = vmf_pkg::BANK_SEL_BITS'(a) * vmf_pkg::BANK_SEL_BITS'(vmf_pkg::WIN) +
                      vmf_pkg::BANK_SEL_BITS'(b);
                new_col[ds*vmf_pkg::WIN + dr] = bank_q[sel];
            end
        end
        new_col[0] = sample1_reg;
    end

    // Shift the column history on every voxel
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            hist_reg[0] <= new_col;
            for (int i = 1; i < vmf_pkg::WIN - 1; i++)
                hist_reg[i] <= hist_reg[i-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < vmf_pkg::WIN_SQ; i++)
        begin
            push_item.win[i] = new_col[i];
            for (int dc = 1; dc < vmf_pkg::WIN; dc++)
                push_item.win[dc*vmf_pkg::WIN_SQ + i] = hist_reg[dc-1][i];
        end
        push_item.col   = ccol1_reg;
        push_item.row   = crow1_reg;
        push_item.slice = cslice1_reg;
        push_item.last  = last1_reg;
    end

    assign push = v1_reg && emit1_reg;

    a_room_for_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> q_status.level < vmf_pkg::QCNT_BITS'(vmf_pkg::QUEUE_DEPTH))
        else $error("window pushed into a full queue");

endmodule

/* rtl/vmf_queue.sv */
// Short queue of complete windows between the front end and the median stages.
module vmf_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  vmf_pkg::item_t         push_item,
    input  logic                   pop,
    output vmf_pkg::item_t         head,
    output vmf_pkg::queue_status_t status
);

    vmf_pkg::item_t                 slot_reg [vmf_pkg::QUEUE_DEPTH];
    logic [vmf_pkg::QPTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [vmf_pkg::QCNT_BITS-1:0]  count_reg, count_next;

    assign head         = slot_reg[rd_ptr_reg];
    assign status.valid = count_reg != '0;
    assign status.level = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= vmf_pkg::QCNT_BITS'(vmf_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

endmodule

/* rtl/vmf_back.sv */
// Back end: rank every window element by comparison and select the median.
module vmf_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vmf_pkg::queue_status_t q_status,
    input  vmf_pkg::item_t         head,
    output logic                   pop,
    vmf_out_if.source              med_out
);

    logic                                    en;
    logic                                    s1_v_reg, s2_v_reg, out_v_reg;
    vmf_pkg::item_t                          s1_item_reg, s2_item_reg;
    logic [vmf_pkg::WIN_CUBE-1:0][vmf_pkg::WIN_CUBE-1:0] beat_next, beat_reg;
    logic [vmf_pkg::WIN_CUBE-1:0]            med_sel_next, med_sel_reg;
    vmf_pkg::sample_t                        med_next;
    logic [vmf_pkg::SAMPLE_BITS-1:0]         med_reg;
    logic [vmf_pkg::COORD_BITS-1:0]          ocol_reg, orow_reg, oslice_reg;
    logic                                    olast_reg;

    // Advance the whole pipeline unless the output register is held
    assign en  = !out_v_reg || med_out.ready;
    assign pop = en && q_status.valid;

    // Element j sits below element i, ties broken by position
    always_comb
    begin
        for (int i = 0; i < vmf_pkg::WIN_CUBE; i++)
        begin
            for (int j = 0; j < vmf_pkg::WIN_CUBE; j++)
            begin
                beat_next[i][j] = ($signed(head.win[j]) < $signed(head.win[i])) ||
                                  ((head.win[j] == head.win[i]) && (j < i));
            end
        end
    end

    // The median is the element with exactly MED_RANK elements below it
    always_comb
    begin
        for (int i = 0; i < vmf_pkg::WIN_CUBE; i++)
            med_sel_next[i] = $countones(beat_reg[i]) == vmf_pkg::MED_RANK;
    end

    always_comb
    begin
        med_next = '0;
        for (int i = 0; i < vmf_pkg::WIN_CUBE; i++)
            med_next = med_next | (med_sel_reg[i] ? s2_item_reg.win[i] : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg  <= pop;
            s2_v_reg  <= s1_v_reg;
            out_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg    <= beat_next;
            s1_item_reg <= head;
            med_sel_reg <= med_sel_next;
            s2_item_reg <= s1_item_reg;
            med_reg     <= med_next;
            ocol_reg    <= s2_item_reg.col;
            orow_reg    <= s2_item_reg.row;
            oslice_reg  <= s2_item_reg.slice;
            olast_reg   <= s2_item_reg.last;
        end
    end

    assign med_out.valid         = out_v_reg;
    assign med_out.median_value  = med_reg;
    assign med_out.center_col    = ocol_reg;
    assign med_out.center_row    = orow_reg;
    assign med_out.center_slice  = oslice_reg;
    assign med_out.last_interior = olast_reg;

    a_one_median: assert property (@(posedge clk) disable iff (!rst_n)
        s2_v_reg |-> $onehot(med_sel_reg))
        else $error("median select not one-hot");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !med_out.ready) |-> !pop ##1 ($stable(med_reg) && out_v_reg))
        else $error("pipeline moved while output held");

endmodule

/* rtl/volume_median_filter_3d_top.sv */
// Top level of the 3x3x3 volume median filter.
// Path of a result: bank read registers, window queue, rank, select and output registers.
// One voxel per cycle unless stalled; each store bank serves one read and one write per cycle.
// Input stalls only when the 4-entry window queue has no room for items in flight.
// Reset: position (0,0,0), dimensions 256 each; the slice store is not cleared.
module volume_median_filter_3d_top (
    input  logic       clk,
    input  logic       rst_n,
    vmf_in_if.sink     vox_in,
    vmf_cfg_if.sink    cfg,
    vmf_out_if.source  med_out
);

    vmf_pkg::queue_status_t q_status;
    vmf_pkg::item_t         push_item;
    vmf_pkg::item_t         head;
    logic                   push;
    logic                   pop;

    vmf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .vox_in    (vox_in),
        .cfg       (cfg),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    vmf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    vmf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .med_out  (med_out)
    );

endmodule
